// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and the crc-8 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int BYTE_W       = 8;
	localparam int SIZE_W       = 7;
	localparam int POS_W        = 6;
	localparam int KIND_W       = 2;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 8;

	localparam logic [SIZE_W-1:0] FRAME_SIZE_LIMIT = 7'd64;
	localparam logic [SIZE_W-1:0] FRAME_SIZE_MIN   = 7'd2;
	localparam logic [BYTE_W-1:0] CRC_POLY         = 8'hD5;

	localparam logic [BYTE_W-1:0] SYNC_RESET     = 8'd234;
	localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 7'd64;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_ADDRESS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_SIZE = 1'd1;

	localparam logic [KIND_W-1:0] KIND_BODY    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD_CRC = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic [BYTE_W-1:0] expected_type;
	} rx_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] body_byte;
		logic [POS_W-1:0]  position;
		logic [BYTE_W-1:0] msg_type;
		logic              type_matches;
		logic [SIZE_W-1:0] frame_size;
	} result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] sync_address;
		logic [SIZE_W-1:0] max_frame_size;
	} cfg_regs_t;

	// msb-first crc-8, one byte
	function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_if
// Valid/ready channels of the frame receiver: received bytes, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface sfr_rx_if;
	import sfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic [BYTE_W-1:0] expected_type;
	modport source (output valid, rx_byte, expected_type, input ready);
	modport sink   (input valid, rx_byte, expected_type, output ready);
endinterface

interface sfr_res_if;
	import sfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] body_byte;
	logic [POS_W-1:0]  position;
	logic [BYTE_W-1:0] msg_type;
	logic              type_matches;
	logic [SIZE_W-1:0] frame_size;
	modport source (output valid, kind, body_byte, position, msg_type, type_matches,
		frame_size, input ready);
	modport sink   (input valid, kind, body_byte, position, msg_type, type_matches,
		frame_size, output ready);
endinterface

interface sfr_cfg_if;
	import sfr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/sfr_in_stage.sv
// ----------------------------------------------------------------------------
// sfr_in_stage
// Input register: holds one received beat until the frame logic takes it.
// ----------------------------------------------------------------------------
module sfr_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sfr_pkg::rx_item_t in_item,
	input  logic              take,
	output logic              valid_s1,
	output sfr_pkg::rx_item_t item_s1
);
	import sfr_pkg::*;

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end
endmodule

// File: rtl/sfr_core.sv
// ----------------------------------------------------------------------------
// sfr_core
// Frame state machine: sync hunt, size check, body bytes with running crc,
// and the crc byte that closes the frame.
// ----------------------------------------------------------------------------
module sfr_core (
	input  logic               clk,
	input  logic               arst_n,
	input  sfr_pkg::cfg_regs_t cfg,
	input  logic               step,
	input  sfr_pkg::rx_item_t  item,
	output logic               has_res,
	output sfr_pkg::result_t   res
);
	import sfr_pkg::*;

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_SIZE = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;
	localparam logic [1:0] PH_CRC  = 2'd3;

	logic [1:0]        phase_q, phase_d;
	logic [SIZE_W-1:0] size_q, size_d;
	logic [POS_W-1:0]  count_q, count_d;
	logic [BYTE_W-1:0] crc_q, crc_d;
	logic [BYTE_W-1:0] type_q, type_d;
	logic [BYTE_W-1:0] ftype;
	logic              size_ok;

	assign size_ok = (item.rx_byte >= {1'b0, FRAME_SIZE_MIN})
		&& (item.rx_byte <= {1'b0, cfg.max_frame_size})
		&& (item.rx_byte <= {1'b0, FRAME_SIZE_LIMIT});
	assign ftype = (count_q == '0) ? item.rx_byte : type_q;

	always_comb begin
		phase_d = phase_q;
		size_d  = size_q;
		count_d = count_q;
		crc_d   = crc_q;
		type_d  = type_q;
		has_res = 1'b0;
		res     = '0;
		case (phase_q)
			PH_HUNT: begin
				size_d = '0;
				if (item.rx_byte == cfg.sync_address) begin
					phase_d = PH_SIZE;
				end
			end
			PH_SIZE: begin
				count_d = '0;
				crc_d   = '0;
				if (size_ok) begin
					size_d  = item.rx_byte[SIZE_W-1:0];
					phase_d = PH_BODY;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_BODY: begin
				has_res          = 1'b1;
				type_d           = ftype;
				crc_d            = crc8_byte(crc_q, item.rx_byte);
				res.kind         = KIND_BODY;
				res.body_byte    = item.rx_byte;
				res.position     = count_q;
				res.msg_type     = ftype;
				res.type_matches = (ftype == item.expected_type);
				res.frame_size   = size_q;
				if (({1'b0, count_q} + 7'd2) >= size_q) begin
					phase_d = PH_CRC;
				end
				count_d = count_q + 6'd1;
			end
			PH_CRC: begin
				has_res          = 1'b1;
				res.kind         = (crc_q == item.rx_byte) ? KIND_GOOD : KIND_BAD_CRC;
				res.msg_type     = type_q;
				res.type_matches = (type_q == item.expected_type);
				res.frame_size   = size_q;
				phase_d          = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			size_q  <= '0;
			count_q <= '0;
			crc_q   <= '0;
			type_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			size_q  <= size_d;
			count_q <= count_d;
			crc_q   <= crc_d;
			type_q  <= type_d;
		end
	end
endmodule

// File: rtl/sfr_out_stage.sv
// ----------------------------------------------------------------------------
// sfr_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module sfr_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sfr_pkg::result_t res_in,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output sfr_pkg::result_t res_q
);
	import sfr_pkg::*;

	logic valid_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res_in;
		end
	end
endmodule

// File: rtl/serial_frame_receiver_crc8_top.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc8_top
// Byte-serial frame receiver with crc-8 (poly 0xd5) check.
//
// rx carries one received byte per beat together with the frame type the
// caller expects. res carries one result beat per body byte (kind body,
// with its position) and one per crc byte (kind good or bad crc). Sync and
// size bytes give no result. cfg writes sync_address (index 0) and
// max_frame_size (index 1); it is always ready. It must be written only while
// idle; the block itself does not enforce this. Each beat is held in an input
// register, the frame logic and the bitwise crc update run on it, and the
// result lands in an output register. A new byte is taken every cycle while
// the output register is free. When res is stalled, one more byte can wait in
// the input register, then rx ready drops until the result is taken.
// Reset clears the frame state to sync hunt, empties both registers and
// restores the register reset values (sync 234, max size 64).
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc8_top (
	input logic      clk,
	input logic      arst_n,
	sfr_rx_if.sink   rx,
	sfr_res_if.source res,
	sfr_cfg_if.sink  cfg
);
	import sfr_pkg::*;

	cfg_regs_t cfg_q;
	rx_item_t  rx_item;
	rx_item_t  item_s1;
	result_t   core_res;
	result_t   res_q;
	logic      valid_s1;
	logic      take;
	logic      has_res;
	logic      out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_address   <= SYNC_RESET;
			cfg_q.max_frame_size <= MAX_SIZE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SYNC_ADDRESS:   cfg_q.sync_address   <= cfg.data;
				REG_MAX_FRAME_SIZE: cfg_q.max_frame_size <= cfg.data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign rx_item.rx_byte       = rx.rx_byte;
	assign rx_item.expected_type = rx.expected_type;

	// a held byte moves on unless its result has nowhere to go
	assign take = valid_s1 && (!has_res || out_free);

	sfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.in_item  (rx_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	sfr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.step    (take),
		.item    (item_s1),
		.has_res (has_res),
		.res     (core_res)
	);

	sfr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && has_res),
		.res_in    (core_res),
		.free      (out_free),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.res_q     (res_q)
	);

	assign res.kind         = res_q.kind;
	assign res.body_byte    = res_q.body_byte;
	assign res.position     = res_q.position;
	assign res.msg_type     = res_q.msg_type;
	assign res.type_matches = res_q.type_matches;
	assign res.frame_size   = res_q.frame_size;
endmodule

// File: rtl/sfr_checker.sv
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
module sfr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [sfr_pkg::KIND_W-1:0] res_kind,
	input logic [sfr_pkg::BYTE_W-1:0] res_body_byte,
	input logic [sfr_pkg::POS_W-1:0]  res_position,
	input logic [sfr_pkg::SIZE_W-1:0] res_frame_size
);
	import sfr_pkg::*;

	// a stalled beat keeps its kind
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind))
		else $error("result beat changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_kind == KIND_BODY || res_kind == KIND_GOOD
			|| res_kind == KIND_BAD_CRC))
		else $error("illegal result kind");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != KIND_BODY |-> res_body_byte == '0 && res_position == '0)
		else $error("status beat carries body data");

	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_frame_size >= FRAME_SIZE_MIN && res_frame_size <= FRAME_SIZE_LIMIT)
		else $error("frame size out of range");

	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_BODY |-> ({1'b0, res_position} + 7'd1) < res_frame_size)
		else $error("body position beyond frame size");
endmodule

bind serial_frame_receiver_crc8_top sfr_checker u_sfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_kind       (res.kind),
	.res_body_byte  (res.body_byte),
	.res_position   (res.position),
	.res_frame_size (res.frame_size)
);

// File: tb/serial_frame_receiver_crc8_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc8_top_tb
// Drives byte streams of framed, truncated, oversized and noisy traffic into
// the frame receiver under several sync / max-size settings, predicts every
// body and crc-status beat with an in-bench model of the receiver and checks
// the result stream beat by beat, with random stalls on both channels and
// one long result-side hold-off that backs up the input.
// ----------------------------------------------------------------------------
module serial_frame_receiver_crc8_top_tb;
	import sfr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;

	typedef enum logic [1:0] {AWAIT_SYNC, AWAIT_SIZE, IN_BODY, AWAIT_CRC} rx_phase_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                 rx_valid  = 1'b0;
	logic [BYTE_W-1:0]    rx_byte_d = '0;
	logic [BYTE_W-1:0]    rx_want_d = '0;
	logic                 res_ready = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic rx_took  = 1'b0;
	logic res_took = 1'b0;
	logic cfg_took = 1'b0;

	sfr_rx_if  rx_ch ();
	sfr_res_if res_ch ();
	sfr_cfg_if cfg_ch ();

	assign rx_ch.valid         = rx_valid;
	assign rx_ch.rx_byte       = rx_byte_d;
	assign rx_ch.expected_type = rx_want_d;
	assign res_ch.ready        = res_ready;
	assign cfg_ch.valid        = cfg_valid;
	assign cfg_ch.index        = cfg_index;
	assign cfg_ch.data         = cfg_data;

	serial_frame_receiver_crc8_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	rx_item_t pending_bytes[$];
	result_t  awaited_results[$];

	int items_queued   = 0;
	int items_accepted = 0;
	int fails          = 0;
	int quiet_cycles   = 0;
	int rx_idle_pct    = 0;
	int res_idle_pct   = 0;
	int hold_requests  = 0;
	int holds_done     = 0;
	int send_wait      = 0;
	int take_wait      = 0;
	int hold_left      = 0;

	// settings as last written, used to shape the traffic
	logic [BYTE_W-1:0] cur_sync = SYNC_RESET;
	logic [SIZE_W-1:0] cur_max  = MAX_SIZE_RESET;

	// receiver model state
	rx_phase_t         rx_ph     = AWAIT_SYNC;
	logic [SIZE_W-1:0] held_size = '0;
	logic [7:0]        body_idx  = '0;
	logic [BYTE_W-1:0] crc_acc   = '0;
	logic [BYTE_W-1:0] held_type = '0;
	logic [BYTE_W-1:0] sync_now  = SYNC_RESET;
	logic [SIZE_W-1:0] max_now   = MAX_SIZE_RESET;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bitwise crc-8, poly 0xd5, msb first
	function automatic logic [BYTE_W-1:0] crc_d5(input logic [BYTE_W-1:0] acc,
			input logic [BYTE_W-1:0] d);
		logic [BYTE_W-1:0] r;
		logic              fb;
		r = acc;
		for (int i = BYTE_W - 1; i >= 0; i--) begin
			fb = r[BYTE_W-1] ^ d[i];
			r  = {r[BYTE_W-2:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic frame_rx_step(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] want);
		result_t r;
		r = '0;
		case (rx_ph)
			AWAIT_SYNC: begin
				held_size = '0;
				if (b == sync_now) begin
					rx_ph = AWAIT_SIZE;
				end
			end
			AWAIT_SIZE: begin
				body_idx = '0;
				crc_acc  = '0;
				if (b >= FRAME_SIZE_MIN && b <= max_now && b <= FRAME_SIZE_LIMIT) begin
					held_size = b[SIZE_W-1:0];
					rx_ph     = IN_BODY;
				end else begin
					rx_ph = AWAIT_SYNC;
				end
			end
			IN_BODY: begin
				if (body_idx == 0) begin
					held_type = b;
				end
				crc_acc        = crc_d5(crc_acc, b);
				r.kind         = KIND_BODY;
				r.body_byte    = b;
				r.position     = body_idx[POS_W-1:0];
				r.msg_type     = held_type;
				r.type_matches = (held_type == want);
				r.frame_size   = held_size;
				awaited_results.push_back(r);
				if (body_idx + 2 >= held_size) begin
					rx_ph = AWAIT_CRC;
				end
				body_idx = body_idx + 8'd1;
			end
			default: begin
				r.kind         = (crc_acc == b) ? KIND_GOOD : KIND_BAD_CRC;
				r.msg_type     = held_type;
				r.type_matches = (held_type == want);
				r.frame_size   = held_size;
				awaited_results.push_back(r);
				rx_ph = AWAIT_SYNC;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [BYTE_W-1:0] e,
			input logic [BYTE_W-1:0] a);
		if (a !== e) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h got %0h", $time, name, e, a);
		end
	endtask

	function automatic int draw_gap(input int pct);
		if (pct != 0 && $urandom_range(99, 0) < pct) begin
			return $urandom_range(18, 1);
		end
		return 0;
	endfunction

	// beat sampling, prediction, checking and watchdog
	always @(posedge clk) begin : beat_check
		result_t want;
		if (arst_n) begin
			rx_took  <= rx_valid && rx_ch.ready;
			res_took <= res_ch.valid && res_ready;
			cfg_took <= cfg_valid && cfg_ch.ready;
			if (cfg_valid && cfg_ch.ready) begin
				case (cfg_index)
					REG_SYNC_ADDRESS:   sync_now = cfg_data;
					REG_MAX_FRAME_SIZE: max_now  = cfg_data[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (rx_valid && rx_ch.ready) begin
				frame_rx_step(rx_byte_d, rx_want_d);
				items_accepted++;
			end
			if (res_ch.valid && res_ready) begin
				if (awaited_results.size() == 0) begin
					fails++;
					$display("%0t: result beat with nothing expected, got kind %0h byte %0h",
						$time, res_ch.kind, res_ch.body_byte);
				end else begin
					want = awaited_results.pop_front();
					check_field("kind", BYTE_W'(want.kind), BYTE_W'(res_ch.kind));
					check_field("body_byte", want.body_byte, res_ch.body_byte);
					check_field("position", BYTE_W'(want.position), BYTE_W'(res_ch.position));
					check_field("msg_type", want.msg_type, res_ch.msg_type);
					check_field("type_matches", BYTE_W'(want.type_matches),
						BYTE_W'(res_ch.type_matches));
					check_field("frame_size", BYTE_W'(want.frame_size),
						BYTE_W'(res_ch.frame_size));
				end
			end
			if ((rx_valid && rx_ch.ready) || (res_ch.valid && res_ready)
					|| (cfg_valid && cfg_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// byte sender
	always @(negedge clk) begin : byte_send
		rx_item_t item;
		if (arst_n && (!rx_valid || rx_took)) begin
			if (send_wait > 0) begin
				send_wait--;
				rx_valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				item = pending_bytes.pop_front();
				rx_valid  <= 1'b1;
				rx_byte_d <= item.rx_byte;
				rx_want_d <= item.expected_type;
				send_wait = draw_gap(rx_idle_pct);
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// result taker, with random stalls and the long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				if (res_took) begin
					take_wait = draw_gap(res_idle_pct);
				end
				if (take_wait > 0) begin
					take_wait--;
					res_ready <= 1'b0;
				end else begin
					res_ready <= 1'b1;
				end
			end
		end
	end

	function automatic void push_item(input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] w);
		rx_item_t item;
		item.rx_byte       = b;
		item.expected_type = w;
		pending_bytes.push_back(item);
		items_queued++;
	endfunction

	// sync, size, n_body body bytes, then the crc byte if asked
	task automatic queue_frame(input int sz, input int n_body, input bit with_crc,
			input bit corrupt, input logic [BYTE_W-1:0] ftype, input bit match);
		logic [BYTE_W-1:0] crc;
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] want;
		crc  = '0;
		want = match ? ftype : ftype ^ BYTE_W'($urandom_range(255, 1));
		push_item(cur_sync, BYTE_W'($urandom_range(255, 0)));
		push_item(BYTE_W'(sz), BYTE_W'($urandom_range(255, 0)));
		for (int i = 0; i < n_body; i++) begin
			b   = (i == 0) ? ftype : BYTE_W'($urandom_range(255, 0));
			crc = crc_d5(crc, b);
			push_item(b, ($urandom_range(3, 0) == 0) ? BYTE_W'($urandom_range(255, 0)) : want);
		end
		if (with_crc) begin
			push_item(corrupt ? crc ^ BYTE_W'($urandom_range(255, 1)) : crc, want);
		end
	endtask

	function automatic int size_cap();
		return (cur_max > FRAME_SIZE_LIMIT) ? int'(FRAME_SIZE_LIMIT) : int'(cur_max);
	endfunction

	function automatic int pick_size();
		int lim;
		lim = size_cap();
		if (lim < 2) begin
			return $urandom_range(12, 2);
		end
		if ($urandom_range(7, 0) == 0) begin
			return $urandom_range(lim, 2);
		end
		if ($urandom_range(15, 0) == 0) begin
			return lim;
		end
		return $urandom_range((lim < 10) ? lim : 10, 2);
	endfunction

	function automatic int bad_size();
		if ($urandom_range(1, 0) == 0) begin
			return $urandom_range(1, 0);
		end
		return $urandom_range(255, size_cap() + 1);
	endfunction

	task automatic queue_traffic(input int n);
		int stop;
		int pick;
		int sz;
		stop = items_queued + n;
		while (items_queued < stop) begin
			pick = $urandom_range(99, 0);
			sz   = pick_size();
			if (pick < 76) begin
				queue_frame(sz, sz - 1, 1'b1, $urandom_range(9, 0) == 0,
					BYTE_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
			end else if (pick < 84) begin
				queue_frame(bad_size(), 0, 1'b0, 1'b0, 8'h00, 1'b0);
			end else if (pick < 92) begin
				// cut short: the bytes that follow land inside the body or its crc slot
				queue_frame(sz, $urandom_range(sz - 1, 0), 1'b0, 1'b0,
					BYTE_W'($urandom_range(255, 0)), 1'b1);
			end else begin
				repeat ($urandom_range(4, 1)) begin
					push_item(BYTE_W'($urandom_range(255, 0)), BYTE_W'($urandom_range(255, 0)));
				end
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_took);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [BYTE_W-1:0] sync, input logic [CFG_DATA_W-1:0] max_size);
		write_reg(REG_SYNC_ADDRESS, sync);
		write_reg(REG_MAX_FRAME_SIZE, max_size);
		cur_sync = sync;
		cur_max  = max_size[SIZE_W-1:0];
	endtask

	// sync and size bytes leave no result, so the wait also counts accepted bytes
	task automatic wait_drained();
		while (items_accepted != items_queued || awaited_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: noise, rejected sizes, short frames, sync value as type
		rx_idle_pct  = 30;
		res_idle_pct = 30;
		push_item(8'h00, 8'hFF);
		push_item(8'hFF, 8'h00);
		queue_frame(0, 0, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_frame(1, 0, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_frame(FRAME_SIZE_LIMIT + 1, 0, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_frame(255, 0, 1'b0, 1'b0, 8'h00, 1'b0);
		queue_frame(2, 1, 1'b1, 1'b0, 8'h00, 1'b1);
		queue_frame(3, 2, 1'b1, 1'b1, 8'hFF, 1'b0);
		queue_frame(4, 3, 1'b1, 1'b0, cur_sync, 1'b1);
		queue_traffic(220);
		wait_drained();

		// max size masked to 127, so the fixed limit decides
		set_regs(8'h00, 8'hFF);
		rx_idle_pct  = 0;
		res_idle_pct = 0;
		queue_traffic(220);
		wait_drained();

		// maximum below 2: every frame is rejected
		set_regs(8'hFF, 8'h00);
		rx_idle_pct  = 60;
		res_idle_pct = 10;
		queue_traffic(80);
		wait_drained();
		set_regs(BYTE_W'($urandom_range(255, 0)), 8'h01);
		queue_traffic(40);
		wait_drained();

		set_regs(BYTE_W'($urandom_range(255, 0)), CFG_DATA_W'(FRAME_SIZE_MIN));
		rx_idle_pct  = 10;
		res_idle_pct = 60;
		queue_traffic(150);
		wait_drained();

		// 200 masks to 72; results held back while bytes keep coming
		set_regs(BYTE_W'($urandom_range(255, 0)), 8'd200);
		rx_idle_pct  = 0;
		res_idle_pct = 0;
		queue_traffic(200);
		hold_requests++;
		wait_drained();

		set_regs(BYTE_W'($urandom_range(255, 0)),
			CFG_DATA_W'($urandom_range(FRAME_SIZE_LIMIT, FRAME_SIZE_MIN)));
		rx_idle_pct  = 50;
		res_idle_pct = 50;
		queue_traffic((items_queued < 1150) ? 1150 - items_queued : 50);
		wait_drained();

		if (fails == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: serial_frame_receiver_crc8_top.f
rtl/sfr_pkg.sv
rtl/sfr_if.sv
rtl/sfr_in_stage.sv
rtl/sfr_core.sv
rtl/sfr_out_stage.sv
rtl/serial_frame_receiver_crc8_top.sv
rtl/sfr_checker.sv
tb/serial_frame_receiver_crc8_top_tb.sv
